// ===== design/van_pkg.sv =====
`timescale 1ns / 1ps

package van_pkg;

  localparam int CompWidth    = 16;
  localparam int CordicSteps  = 24;
  localparam int CorWidth     = 44;
  localparam int ZWidth       = 26;
  localparam int SqrtBits     = 64;
  localparam int SqrtPerStage = 4;

  typedef struct packed {
    logic [CompWidth-1:0] a_x;
    logic [CompWidth-1:0] a_y;
    logic [CompWidth-1:0] a_z;
    logic [CompWidth-1:0] b_x;
    logic [CompWidth-1:0] b_y;
    logic [CompWidth-1:0] b_z;
  } in_word_t;

  typedef struct packed {
    logic [16:0] angle_norm;
    logic        degenerate;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
    logic dneg;
  } flags_t;

  function automatic logic signed [ZWidth-1:0] atan_val(input int i);
    logic signed [ZWidth-1:0] t;
    case (i)
      0: t = 26'sd4194304;  1: t = 26'sd2476042;  2: t = 26'sd1308273;
      3: t = 26'sd664100;   4: t = 26'sd333339;   5: t = 26'sd166832;
      6: t = 26'sd83436;    7: t = 26'sd41721;    8: t = 26'sd20861;
      9: t = 26'sd10430;    10: t = 26'sd5215;    11: t = 26'sd2608;
      12: t = 26'sd1304;    13: t = 26'sd652;     14: t = 26'sd326;
      15: t = 26'sd163;     16: t = 26'sd81;      17: t = 26'sd41;
      18: t = 26'sd20;      19: t = 26'sd10;      20: t = 26'sd5;
      21: t = 26'sd3;       22: t = 26'sd1;       23: t = 26'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/van_front.sv =====
`timescale 1ns / 1ps

// Products: fit, dot, squared cross magnitude.
module van_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  van_pkg::in_word_t   in_word,
  output van_pkg::flags_t     flags,
  output logic [47:0]         dmag,
  output logic [63:0]         c2
);

  localparam int CompWidth = van_pkg::CompWidth;
  localparam int Shift     = (CompWidth > 16) ? CompWidth - 16 : 0;

  logic signed [15:0] a [3];
  logic signed [15:0] b [3];
  logic signed [31:0] pd [3];
  logic signed [31:0] pc [6];
  logic               deg_s1;
  logic               valid_s1;
  logic signed [33:0] dot;
  logic signed [32:0] cr [3];
  logic               a_zero;
  logic               b_zero;

  // Fit one vector to 16 bits: shift by smallest amount bringing all in range.
  function automatic void fit(input logic signed [CompWidth-1:0] v0,
                              input logic signed [CompWidth-1:0] v1,
                              input logic signed [CompWidth-1:0] v2,
                              output logic signed [15:0] o0,
                              output logic signed [15:0] o1,
                              output logic signed [15:0] o2);
    logic signed [CompWidth-1:0] t0, t1, t2;
    int s;
    logic found;
    t0 = v0;
    t1 = v1;
    t2 = v2;
    found = 1'b0;
    for (s = 0; s <= Shift; s++) begin
      if (!found) begin
        t0 = v0 >>> s;
        t1 = v1 >>> s;
        t2 = v2 >>> s;
        if ((t0 >= -32768) && (t0 <= 32767) && (t1 >= -32768) && (t1 <= 32767) &&
            (t2 >= -32768) && (t2 <= 32767)) begin
          found = 1'b1;
        end
      end
    end
    o0 = 16'(t0);
    o1 = 16'(t1);
    o2 = 16'(t2);
  endfunction

  always_comb begin
    fit(signed'(in_word.a_x), signed'(in_word.a_y), signed'(in_word.a_z),
        a[0], a[1], a[2]);
    fit(signed'(in_word.b_x), signed'(in_word.b_y), signed'(in_word.b_z),
        b[0], b[1], b[2]);
    a_zero = (in_word.a_x == '0) && (in_word.a_y == '0) && (in_word.a_z == '0);
    b_zero = (in_word.b_x == '0) && (in_word.b_y == '0) && (in_word.b_z == '0);
  end

  // Stage 1: register multiplies.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else if (adv) begin
      valid_s1 <= in_valid;
    end
    if (adv) begin
      deg_s1 <= a_zero || b_zero;
      for (int i = 0; i < 3; i++) begin
        pd[i] <= a[i] * b[i];
      end
      pc[0] <= a[1] * b[2];
      pc[1] <= a[2] * b[1];
      pc[2] <= a[2] * b[0];
      pc[3] <= a[0] * b[2];
      pc[4] <= a[0] * b[1];
      pc[5] <= a[1] * b[0];
    end
  end

  always_comb begin
    dot = 34'(pd[0]) + 34'(pd[1]) + 34'(pd[2]);
    cr[0] = 33'(pc[0]) - 33'(pc[1]);
    cr[1] = 33'(pc[2]) - 33'(pc[3]);
    cr[2] = 33'(pc[4]) - 33'(pc[5]);
  end

  logic [31:0] cm [3];
  logic        valid_s2;
  logic        deg_s2;
  logic        dneg_s2;
  logic [33:0] dmag_s2;

  // Stage 2: cross magnitudes, dot sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s2 <= 1'b0;
    end else if (adv) begin
      valid_s2 <= valid_s1;
    end
    if (adv) begin
      deg_s2  <= deg_s1;
      dneg_s2 <= dot[33];
      dmag_s2 <= dot[33] ? 34'(-dot) : 34'(dot);
      for (int i = 0; i < 3; i++) begin
        cm[i] <= cr[i][32] ? 32'(-cr[i]) : 32'(cr[i]);
      end
    end
  end

  logic [63:0] sq [3];
  logic        valid_s3;
  logic        deg_s3;
  logic        dneg_s3;
  logic [33:0] dmag_s3;

  // Stage 3: squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s3 <= 1'b0;
    end else if (adv) begin
      valid_s3 <= valid_s2;
    end
    if (adv) begin
      deg_s3  <= deg_s2;
      dneg_s3 <= dneg_s2;
      dmag_s3 <= dmag_s2;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= cm[i] * cm[i];
      end
    end
  end

  // Stage 4: sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.valid <= 1'b0;
    end else if (adv) begin
      flags.valid <= valid_s3;
    end
    if (adv) begin
      flags.degenerate <= deg_s3;
      flags.dneg       <= dneg_s3;
      dmag             <= 48'(dmag_s3);
      c2               <= sq[0] + sq[1] + sq[2];
    end
  end

endmodule

// ===== design/van_sqrt.sv =====
`timescale 1ns / 1ps

// Normalize c2 by 4s, pipelined integer sqrt, scale x along.
module van_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  van_pkg::flags_t in_flags,
  input  logic [47:0]     in_dmag,
  input  logic [63:0]     in_c2,
  output van_pkg::flags_t flags,
  output logic [95:0]     ux,
  output logic [31:0]     uy
);

  localparam int Steps  = van_pkg::SqrtBits / 2;
  localparam int Stages = Steps / van_pkg::SqrtPerStage;

  logic [63:0] c2n;
  logic [5:0]  m;
  logic [6:0]  lz;

  always_comb begin
    lz = 7'd64;
    for (int k = 0; k < 64; k++) begin
      if (in_c2[k]) begin
        lz = 7'(63 - k);
      end
    end
    m   = (in_c2 == '0) ? '0 : lz[6:1];
    c2n = in_c2 << {m, 1'b0};
  end

  van_pkg::flags_t fl [Stages + 1];
  logic [63:0]     rem [Stages + 1];
  logic [31:0]     root [Stages + 1];
  logic [95:0]     xs [Stages + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fl[0].valid <= 1'b0;
    end else if (adv) begin
      fl[0].valid <= in_flags.valid;
    end
    if (adv) begin
      fl[0].degenerate <= in_flags.degenerate;
      fl[0].dneg       <= in_flags.dneg;
      rem[0]           <= c2n;
      root[0]          <= '0;
      xs[0]            <= 96'(in_dmag) << m;
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_sq
    logic [63:0] r_n;
    logic [31:0] q_n;
    always_comb begin
      logic [65:0] trial;
      r_n = rem[g];
      q_n = root[g];
      for (int j = 0; j < van_pkg::SqrtPerStage; j++) begin
        trial = {2'b0, r_n} - ({32'b0, q_n, 2'b01} << (62 - 2 * (g * van_pkg::SqrtPerStage + j)));
        if (!trial[65]) begin
          r_n = trial[63:0];
          q_n = {q_n[30:0], 1'b1};
        end else begin
          q_n = {q_n[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        fl[g + 1].valid <= 1'b0;
      end else if (adv) begin
        fl[g + 1].valid <= fl[g].valid;
      end
      if (adv) begin
        fl[g + 1].degenerate <= fl[g].degenerate;
        fl[g + 1].dneg       <= fl[g].dneg;
        rem[g + 1]           <= r_n;
        root[g + 1]          <= q_n;
        xs[g + 1]            <= xs[g];
      end
    end
  end

  assign flags = fl[Stages];
  assign ux    = xs[Stages];
  assign uy    = root[Stages];

  logic unused;
  assign unused = ^rem[Stages];

endmodule

// ===== design/van_cordic.sv =====
`timescale 1ns / 1ps

// Range align, then vectoring CORDIC, two steps per stage, then round.
module van_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  van_pkg::flags_t in_flags,
  input  logic [95:0]     in_ux,
  input  logic [31:0]     in_uy,
  output logic            out_valid,
  output van_pkg::out_word_t out_word
);

  localparam int W      = van_pkg::CorWidth;
  localparam int ZW     = van_pkg::ZWidth;
  localparam int PerSt  = 2;
  localparam int Stages = van_pkg::CordicSteps / PerSt;

  // Align: find top bit of (ux | uy) and place it at bit 39.
  logic [95:0] orv;
  logic [6:0]  top;
  logic [95:0] xa;
  logic [95:0] ya;

  always_comb begin
    orv = in_ux | 96'(in_uy);
    top = 7'd39;
    for (int k = 0; k < 96; k++) begin
      if (orv[k]) begin
        top = 7'(k);
      end
    end
    if (top >= 7'd39) begin
      xa = in_ux >> (top - 7'd39);
      ya = 96'(in_uy) >> (top - 7'd39);
    end else begin
      xa = in_ux << (7'd39 - top);
      ya = 96'(in_uy) << (7'd39 - top);
    end
  end

  logic                 vs [Stages + 1];
  logic                 ds [Stages + 1];
  logic signed [W-1:0]  xs [Stages + 1];
  logic signed [W-1:0]  ys [Stages + 1];
  logic signed [ZW-1:0] zs [Stages + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (adv) begin
      vs[0] <= in_flags.valid;
    end
    if (adv) begin
      ds[0] <= in_flags.degenerate;
      if (in_flags.dneg) begin
        xs[0] <= W'(ya[40:0]);
        ys[0] <= W'(xa[40:0]);
        zs[0] <= ZW'(8388608);
      end else begin
        xs[0] <= W'(xa[40:0]);
        ys[0] <= W'(ya[40:0]);
        zs[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < Stages; g++) begin : g_cor
    logic signed [W-1:0]  xn, yn;
    logic signed [ZW-1:0] zn;
    always_comb begin
      logic signed [W-1:0] xt;
      int i;
      xn = xs[g];
      yn = ys[g];
      zn = zs[g];
      for (int j = 0; j < PerSt; j++) begin
        i = g * PerSt + j;
        if (!yn[W-1]) begin
          xt = xn + (yn >>> i);
          yn = yn - (xn >>> i);
          zn = zn + van_pkg::atan_val(i);
        end else begin
          xt = xn - (yn >>> i);
          yn = yn + (xn >>> i);
          zn = zn - van_pkg::atan_val(i);
        end
        xn = xt;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[g + 1] <= 1'b0;
      end else if (adv) begin
        vs[g + 1] <= vs[g];
      end
      if (adv) begin
        ds[g + 1] <= ds[g];
        xs[g + 1] <= xn;
        ys[g + 1] <= yn;
        zs[g + 1] <= zn;
      end
    end
  end

  logic signed [ZW-1:0] zr;
  always_comb begin
    zr = (zs[Stages] + ZW'(128)) >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vs[Stages];
    end
    if (adv) begin
      out_word.degenerate <= ds[Stages];
      if (ds[Stages] || zr < 0) begin
        out_word.angle_norm <= '0;
      end else if (zr > ZW'(65536)) begin
        out_word.angle_norm <= 17'd65536;
      end else begin
        out_word.angle_norm <= 17'(zr);
      end
    end
  end

  logic unused;
  assign unused = ^{xs[Stages], ys[Stages], xa[95:41], ya[95:41]};

endmodule

// ===== design/vector_angle_normalized_core.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle; the whole pipeline holds while an output word waits under out stall.
// in stall is high exactly when a valid output word is stalled: the pipeline advances otherwise.
// Reset clears every stage valid bit; payload registers are not reset.
module vector_angle_normalized_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  van_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output van_pkg::out_word_t out_word
);

  logic            adv;
  van_pkg::flags_t f_fl, s_fl;
  logic [47:0]     dmag;
  logic [63:0]     c2;
  logic [95:0]     ux;
  logic [31:0]     uy;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  van_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid), .in_word(in_word),
    .flags(f_fl), .dmag(dmag), .c2(c2)
  );

  van_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_flags(f_fl), .in_dmag(dmag), .in_c2(c2),
    .flags(s_fl), .ux(ux), .uy(uy)
  );

  van_cordic u_cordic (
    .clk(clk), .rst(rst), .adv(adv), .in_flags(s_fl), .in_ux(ux), .in_uy(uy),
    .out_valid(out_valid), .out_word(out_word)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.degenerate |-> out_word.angle_norm == '0)
    else $error("degenerate word with nonzero angle");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.angle_norm <= 17'd65536)
    else $error("angle out of range");

endmodule
